// ===== rtl/core/rdu_pkg.sv =====
`default_nettype none
package rdu_pkg;

    // Component format: signed, CW bits, FRAC fraction bits.
    localparam int CW         = 16;
    localparam int FRAC       = CW - 2;
    localparam int RATIO_W    = 16;
    localparam int INV_W      = 15;
    localparam int RATIO_FRAC = 14;

    // Derived datapath widths.
    localparam int PROD_W  = 2 * CW;
    localparam int SUM_W   = 2 * CW + 2;
    localparam int COS_W   = FRAC + 1;
    localparam int NRM_W   = CW + 1;
    localparam int T1_W    = CW + 2;
    localparam int RC_W    = FRAC + 2;
    localparam int K_W     = FRAC + 6;
    localparam int ROOT_W  = FRAC + 1;
    localparam int REM_W   = 2 * ROOT_W + 2;
    localparam int COEF_W  = FRAC + 3;
    localparam int P2_W    = COEF_W + NRM_W;
    localparam int CFG_W   = RATIO_W;

    localparam logic [RATIO_W-1:0] REFRACTION_INDEX_RESET = 16'd21791;
    localparam logic [INV_W-1:0]   INVERSE_INDEX_RESET    = 15'd12319;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_REFRACTION_INDEX = 1'b0,
        REG_INVERSE_INDEX    = 1'b1
    } rdu_reg_t;

    typedef struct packed {
        logic signed [CW-1:0] incident_x;
        logic signed [CW-1:0] incident_y;
        logic signed [CW-1:0] incident_z;
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
    } rdu_in_t;

    typedef struct packed {
        logic                 refracted;
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
    } rdu_out_t;

    // Values that ride alongside the square root pipeline.
    typedef struct packed {
        logic                          tir;
        logic [RC_W-1:0]               rc;
        logic [2:0][T1_W-1:0]          t1;
        logic [2:0][NRM_W-1:0]         nrm;
    } rdu_side_t;

endpackage
`default_nettype wire

// ===== rtl/core/refraction_direction_unit.sv =====
// Refraction direction unit: Snell's law in vector form on Q1.14 components.
// Input channel (in_valid, in_stall, in_data) carries an incident direction
// and a surface normal; output channel (out_valid, out_stall, out_data)
// carries the refracted flag and the saturated refracted direction, all
// zero on total internal reflection. A transaction happens on a rising edge
// with valid high and stall low.
// The pipeline has four front stages (products, dot product and case
// select, squares, k), one stage per root bit (15) and three back stages.
// Throughput is one transaction per cycle while no held result stalls it;
// the bit-per-stage root pipeline sets the depth but not the rate.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads refraction_index = 21791 and
// inverse_index = 12319. The user writes registers via cfg_we, cfg_index,
// cfg_data only while no transaction is in flight; the unit does not check.
`default_nettype none
module refraction_direction_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire rdu_pkg::rdu_in_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output rdu_pkg::rdu_out_t                out_data,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [rdu_pkg::CFG_W-1:0]   cfg_data
);
    import rdu_pkg::*;

    logic [RATIO_W-1:0] refraction_index_reg;
    logic [INV_W-1:0]   inverse_index_reg;
    logic               en;

    logic                  sv [ROOT_W+1];
    logic [REM_W-1:0]      srem [ROOT_W+1];
    logic [ROOT_W-1:0]     sroot [ROOT_W+1];
    rdu_side_t             sside [ROOT_W+1];

    // The pipeline moves unless a finished result is held by the receiver.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refraction_index_reg <= REFRACTION_INDEX_RESET;
            inverse_index_reg    <= INVERSE_INDEX_RESET;
        end
        else if (cfg_we)
        begin
            case (rdu_reg_t'(cfg_index))
                REG_REFRACTION_INDEX: refraction_index_reg <= cfg_data;
                REG_INVERSE_INDEX:    inverse_index_reg    <= cfg_data[INV_W-1:0];
                default:              ;
            endcase
        end
    end

    rdu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (in_valid),
        .in_data          (in_data),
        .refraction_index (refraction_index_reg),
        .inverse_index    (inverse_index_reg),
        .valid            (sv[0]),
        .rem              (srem[0]),
        .side             (sside[0])
    );

    assign sroot[0] = '0;

    // Square root, one result bit per stage from the top.
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        rdu_sqrt_stage #(
            .J (ROOT_W - 1 - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sv[g]),
            .in_rem    (srem[g]),
            .in_root   (sroot[g]),
            .in_side   (sside[g]),
            .out_valid (sv[g+1]),
            .out_rem   (srem[g+1]),
            .out_root  (sroot[g+1]),
            .out_side  (sside[g+1])
        );
    end

    rdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv[ROOT_W]),
        .root      (sroot[ROOT_W]),
        .side      (sside[ROOT_W]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // The final remainder is not needed downstream.
    logic unused_rem;
    assign unused_rem = ^srem[ROOT_W];

endmodule
`default_nettype wire

// ===== rtl/core/rdu_front.sv =====
`default_nettype none
module rdu_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire rdu_pkg::rdu_in_t             in_data,
    input  wire logic [rdu_pkg::RATIO_W-1:0]  refraction_index,
    input  wire logic [rdu_pkg::INV_W-1:0]    inverse_index,
    output logic                              valid,
    output logic [rdu_pkg::REM_W-1:0]         rem,
    output rdu_pkg::rdu_side_t                side
);
    import rdu_pkg::*;

    localparam logic [SUM_W-1:0]   ONE_SUM = SUM_W'(1) << FRAC;
    localparam logic [2*COS_W-1:0] ONE_SQ  = (2*COS_W)'(1) << (2 * FRAC);
    localparam logic [K_W-1:0]     ONE_K   = K_W'(1) << FRAC;

    // Stage 1 registers: inputs and component products.
    logic                            v1_reg;
    logic [2:0][CW-1:0]              inc1_reg, nrm1_reg;
    logic [2:0][PROD_W-1:0]          p1_reg;

    // Stage 2 registers: case selection.
    logic                            v2_reg;
    logic [COS_W-1:0]                cos2_reg;
    logic [RATIO_W-1:0]              ratio2_reg;
    logic [2:0][CW-1:0]              inc2_reg;
    logic [2:0][NRM_W-1:0]           nrm2_reg;

    // Stage 3 registers: squares and ratio products.
    logic                            v3_reg;
    logic [COS_W-1:0]                sin2_reg;
    logic [2*RATIO_W-1:0]            r2_reg;
    logic [RC_W-1:0]                 rc3_reg;
    logic [2:0][T1_W-1:0]            t13_reg;
    logic [2:0][NRM_W-1:0]           nrm3_reg;

    // Stage 4 registers: radicand and reflection flag.
    logic                            v4_reg;
    logic [REM_W-1:0]                rem4_reg;
    rdu_side_t                       side4_reg;

    logic [2:0][CW-1:0]              inc_in, nrm_in;
    logic [2:0][PROD_W-1:0]          p_next;
    logic signed [SUM_W-1:0]         sum, dot, mag;
    logic                            neg;
    logic [COS_W-1:0]                cos_next;
    logic [RATIO_W-1:0]              ratio_next;
    logic [2:0][NRM_W-1:0]           nrm_next;
    logic [2*COS_W-1:0]              cos_sq;
    logic [COS_W-1:0]                sin2_next;
    logic [RATIO_W+COS_W-1:0]        rcp;
    logic [2:0][T1_W-1:0]            t1_next;
    logic signed [CW+RATIO_W:0]      tp [3];
    logic signed [CW+RATIO_W:0]      tps [3];
    logic [2*RATIO_W+COS_W-1:0]      xp;
    logic [FRAC+4:0]                 xs;
    logic signed [K_W-1:0]           k;
    logic                            tir_next;
    logic [REM_W-1:0]                rem_next;

    assign inc_in = {in_data.incident_z, in_data.incident_y, in_data.incident_x};
    assign nrm_in = {in_data.normal_z, in_data.normal_y, in_data.normal_x};

    // Products of the dot product.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = PROD_W'($signed(inc_in[i]) * $signed(nrm_in[i]));
        end
    end

    // Dot product, cosine clamp, ratio and normal orientation.
    always_comb
    begin
        sum = SUM_W'($signed(p1_reg[0])) + SUM_W'($signed(p1_reg[1]))
            + SUM_W'($signed(p1_reg[2]));
        dot = sum >>> FRAC;
        neg = dot[SUM_W-1];
        mag = neg ? -dot : dot;
        cos_next = (mag > $signed(ONE_SUM)) ? ONE_SUM[COS_W-1:0] : mag[COS_W-1:0];
        ratio_next = neg ? {1'b0, inverse_index} : refraction_index;
        for (int i = 0; i < 3; i++)
        begin
            nrm_next[i] = neg ? NRM_W'($signed(nrm1_reg[i]))
                              : -NRM_W'($signed(nrm1_reg[i]));
        end
    end

    // Sine squared, ratio squared, ratio times cosine and ratio times incident.
    always_comb
    begin
        cos_sq    = cos2_reg * cos2_reg;
        sin2_next = COS_W'((ONE_SQ - cos_sq) >> FRAC);
        rcp       = ratio2_reg * cos2_reg;
        for (int i = 0; i < 3; i++)
        begin
            tp[i]      = $signed({1'b0, ratio2_reg}) * $signed(inc2_reg[i]);
            tps[i]     = tp[i] >>> RATIO_FRAC;
            t1_next[i] = tps[i][T1_W-1:0];
        end
    end

    // k and the radicand for the root.
    always_comb
    begin
        xp       = r2_reg * sin2_reg;
        xs       = xp[2*RATIO_FRAC +: FRAC+5];
        k        = $signed(ONE_K) - $signed({1'b0, xs});
        tir_next = k[K_W-1];
        rem_next = tir_next ? '0 : (REM_W'(k[FRAC:0]) << FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inc1_reg   <= inc_in;
            nrm1_reg   <= nrm_in;
            p1_reg     <= p_next;
            cos2_reg   <= cos_next;
            ratio2_reg <= ratio_next;
            inc2_reg   <= inc1_reg;
            nrm2_reg   <= nrm_next;
            sin2_reg   <= sin2_next;
            r2_reg     <= ratio2_reg * ratio2_reg;
            rc3_reg    <= RC_W'(rcp >> RATIO_FRAC);
            t13_reg    <= t1_next;
            nrm3_reg   <= nrm2_reg;
            rem4_reg   <= rem_next;
            side4_reg.tir <= tir_next;
            side4_reg.rc  <= rc3_reg;
            side4_reg.t1  <= t13_reg;
            side4_reg.nrm <= nrm3_reg;
        end
    end

    assign valid = v4_reg;
    assign rem   = rem4_reg;
    assign side  = side4_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rdu_sqrt_stage.sv =====
`default_nettype none
module rdu_sqrt_stage #(
    parameter int J = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rdu_pkg::REM_W-1:0]     in_rem,
    input  wire logic [rdu_pkg::ROOT_W-1:0]    in_root,
    input  wire rdu_pkg::rdu_side_t            in_side,
    output logic                               out_valid,
    output logic [rdu_pkg::REM_W-1:0]          out_rem,
    output logic [rdu_pkg::ROOT_W-1:0]         out_root,
    output rdu_pkg::rdu_side_t                 out_side
);
    import rdu_pkg::*;

    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg, rem_next, trial;
    logic [ROOT_W-1:0] root_reg, root_next;

    // One result bit: try setting bit J of the root against the remainder.
    always_comb
    begin
        trial = (REM_W'(in_root) << (J + 1)) + (REM_W'(1) << (2 * J));
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = in_root | (ROOT_W'(1) << J);
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            out_side <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rdu_back.sv =====
`default_nettype none
module rdu_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rdu_pkg::ROOT_W-1:0]    root,
    input  wire rdu_pkg::rdu_side_t            side,
    output logic                               out_valid,
    output rdu_pkg::rdu_out_t                  out_data
);
    import rdu_pkg::*;

    localparam int S_W = P2_W + 1;
    localparam logic signed [S_W-1:0] SMAX = S_W'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [S_W-1:0] SMIN = -SMAX - S_W'(1);

    logic                     v1_reg, v2_reg, v3_reg;
    logic [COEF_W-1:0]        coef_reg;
    rdu_side_t                side1_reg;
    logic [2:0][P2_W-1:0]     p_reg;
    logic [2:0][T1_W-1:0]     t1_reg;
    logic                     tir_reg;
    rdu_out_t                 out_reg, out_next;

    logic signed [P2_W-1:0]   t2 [3];
    logic signed [S_W-1:0]    s  [3];
    logic [2:0][CW-1:0]       o;
    logic [2:0][P2_W-1:0]     p_next;

    // Correction products along the normal.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = P2_W'($signed(coef_reg) * $signed(side1_reg.nrm[i]));
        end
    end

    // Sum, saturation and the reflection case.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t2[i] = $signed(p_reg[i]) >>> FRAC;
            s[i]  = S_W'(t2[i]) + S_W'($signed(t1_reg[i]));
            if (s[i] > SMAX)
            begin
                o[i] = SMAX[CW-1:0];
            end
            else if (s[i] < SMIN)
            begin
                o[i] = SMIN[CW-1:0];
            end
            else
            begin
                o[i] = s[i][CW-1:0];
            end
        end
        out_next.refracted = !tir_reg;
        out_next.out_x = tir_reg ? '0 : o[0];
        out_next.out_y = tir_reg ? '0 : o[1];
        out_next.out_z = tir_reg ? '0 : o[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg  <= COEF_W'({1'b0, side.rc}) - COEF_W'(root);
            side1_reg <= side;
            p_reg     <= p_next;
            t1_reg    <= side1_reg.t1;
            tir_reg   <= side1_reg.tir;
            out_reg   <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rdu_checker.sv =====
`default_nettype none
module rdu_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire rdu_pkg::rdu_out_t  out_data
);
    import rdu_pkg::*;

    // A held result stays presented.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    // Total internal reflection reports a zero direction.
    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.refracted |->
            out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
        else $error("nonzero direction on total internal reflection");

    // Input back-pressure only comes from a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

endmodule

bind refraction_direction_unit rdu_checker u_rdu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
